// ----- sv/nbs_pkg.sv -----
// Package for the naive Bayes sparse scorer: widths, input modes, sequencer states
// and saturation helpers. No dependencies.
package nbs_pkg;
    localparam int FEATURES   = 4096;
    localparam int CLASSES    = 8;
    localparam int LOGP_WIDTH = 24;
    localparam int FEAT_W     = 12;
    localparam int CLS_W      = 3;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 32;
    localparam int NORM_W     = 10;
    localparam int CCNT_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int MEM_AW     = FEAT_W + CLS_W;
    // Dividend of the rounding divide: magnitude times norm plus half the length.
    localparam int DIVD_W     = SUM_W + NORM_W + 1;

    localparam logic [MODE_W-1:0] MODE_FEAT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRIOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TERM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_NORM = 1'b1;

    localparam logic signed [SUM_W-1:0] S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_FIN_READ,
        ST_FIN_MUL,
        ST_FIN_DIV,
        ST_FIN_CMP,
        ST_OUT
    } nbs_state_t;

    // Saturate a 50-bit signed sum down to 48 bits.
    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W+1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > $signed({{2{S48_MAX[SUM_W-1]}}, S48_MAX}))
            r = S48_MAX;
        else if (v < $signed({{2{S48_MIN[SUM_W-1]}}, S48_MIN}))
            r = S48_MIN;
        else
            r = v[SUM_W-1:0];
        return r;
    endfunction
endpackage

// ----- sv/nbs_if.sv -----
// Valid/ready channel interfaces for the scorer's input and result transactions.
// Depends on nbs_pkg.
interface nbs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [nbs_pkg::MODE_W-1:0]           mode;
    logic [nbs_pkg::FEAT_W-1:0]           feature_index;
    logic [nbs_pkg::CLS_W-1:0]            class_index;
    logic signed [nbs_pkg::LOGP_WIDTH-1:0] log_prob;
    logic [nbs_pkg::CNT_W-1:0]            term_count;
    logic                                 last_term;
    modport source (output valid, mode, feature_index, class_index, log_prob,
                    term_count, last_term, input ready);
    modport sink   (input valid, mode, feature_index, class_index, log_prob,
                    term_count, last_term, output ready);
endinterface

interface nbs_out_if;
    logic                              valid;
    logic                              ready;
    logic [nbs_pkg::CCNT_W-1:0]        predicted_class;
    logic signed [nbs_pkg::SUM_W-1:0]  best_score;
    modport source (output valid, predicted_class, best_score, input ready);
    modport sink   (input valid, predicted_class, best_score, output ready);
endinterface

// ----- sv/nbs_table_ram.sv -----
// Feature log-probability table: one write port, one registered read port.
// Depends on nbs_pkg.
module nbs_table_ram (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [nbs_pkg::MEM_AW-1:0]            waddr,
    input  logic signed [nbs_pkg::LOGP_WIDTH-1:0] wdata,
    input  logic [nbs_pkg::MEM_AW-1:0]            raddr,
    output logic signed [nbs_pkg::LOGP_WIDTH-1:0] rdata
);
    import nbs_pkg::*;

    logic signed [LOGP_WIDTH-1:0] mem [FEATURES*CLASSES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/nbs_divider.sv -----
// Restoring divider, one quotient bit per cycle, for length normalization.
// Depends on nbs_pkg.
module nbs_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [nbs_pkg::DIVD_W-1:0]         dividend,
    input  logic [nbs_pkg::LEN_W-1:0]          divisor,
    output logic                               done,
    output logic [nbs_pkg::DIVD_W-1:0]         quotient
);
    import nbs_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [LEN_W:0]    rem_reg, rem_next;
    logic [LEN_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [LEN_W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[LEN_W-1:0], quo_reg[DIVD_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = trial - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = busy_reg && (step_reg == STEP_W'(1));
    assign quotient = quo_next;
endmodule

// ----- sv/naive_bayes_sparse_scorer.sv -----
// Top level of the multinomial naive Bayes sparse scorer: sequencer, class sums,
// shared multiply-add and compare. Depends on nbs_pkg, nbs_if, nbs_table_ram,
// nbs_divider.
//
// Usage: the in channel carries one transaction per table write or sample term.
// Mode 0 writes a feature log-probability, mode 1 a class log-prior, mode 2 is a
// sample term. Terms of a sample accumulate log-prob times count into one
// 48-bit sum per class; the term marked last produces one out transaction with
// the one-based winning class and its score. Configuration (class count,
// length norm) is written through cfg_we/cfg_index/cfg_data while idle.
// Sequence: a table write or an ignored transaction is taken in its accept cycle.
// A term passes through the accept cycle, a table read state and one shared
// multiply-add per class. A term marked last then runs the final scoring
// pass over the active classes one at a time: read and compare without
// normalization; read, multiply, bit-serial divide and compare with it.
// After reset the class sums and sample length are zero, class count is 8 and
// normalization is off; the tables are undefined until written.
// The result sits in an output register; while the receiver stalls the block
// holds it and takes no new transaction.
module naive_bayes_sparse_scorer (
    input  logic                         clk,
    input  logic                         rst_n,
    nbs_in_if.sink                       in_ch,
    nbs_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [nbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nbs_pkg::*;

    localparam int CI_W = CLS_W + 1;

    nbs_state_t state_reg, state_next;

    logic [CCNT_W-1:0] num_classes_reg;
    logic [NORM_W-1:0] length_norm_reg;

    logic signed [SUM_W-1:0]      sum_reg [CLASSES];
    logic signed [LOGP_WIDTH-1:0] prior_reg [CLASSES];
    logic [LEN_W-1:0]             len_reg;

    logic [FEAT_W-1:0] feat_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;
    logic [CI_W-1:0]   rd_idx_reg;  // class being read
    logic [CI_W-1:0]   ac_idx_reg;  // class being accumulated / scored
    logic [CI_W-1:0]   active_reg;

    logic signed [SUM_W-1:0] score_reg;
    logic                    neg_reg;
    logic [DIVD_W-1:0]       divd_reg;
    logic signed [SUM_W-1:0] best_reg;
    logic [CCNT_W-1:0]       best_cls_reg;
    logic                    out_valid_reg;
    logic                    div_go_reg;

    logic                         in_fire;
    logic                         ram_we;
    logic signed [LOGP_WIDTH-1:0] ram_rdata;
    logic                         div_start;
    logic                         div_done;
    logic [DIVD_W-1:0]            div_q;
    logic                         norm_on;
    logic signed [SUM_W+1:0]      prod;
    logic [SUM_W-1:0]             mag;
    logic [SUM_W-1:0]             q_sat;
    logic signed [SUM_W-1:0]      scaled;
    logic signed [SUM_W-1:0]      final_s;
    logic [LEN_W:0]               len_sum;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign ram_we  = in_fire && (in_ch.mode == MODE_FEAT);
    assign norm_on = (length_norm_reg != '0) && (len_reg != '0);

    nbs_table_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({in_ch.feature_index, in_ch.class_index}),
        .wdata (in_ch.log_prob),
        .raddr ({feat_reg, rd_idx_reg[CLS_W-1:0]}),
        .rdata (ram_rdata)
    );

    nbs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (divd_reg),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared multiply-add: one class per cycle.
    assign prod = $signed({{2{sum_reg[ac_idx_reg[CLS_W-1:0]][SUM_W-1]}},
                           sum_reg[ac_idx_reg[CLS_W-1:0]]})
                + (SUM_W+2)'($signed(ram_rdata) * $signed({1'b0, cnt_reg}));

    // Scaling path.
    assign q_sat  = (div_q > DIVD_W'(S48_MAX)) ?
                    (neg_reg ? SUM_W'(S48_MIN) : SUM_W'(S48_MAX)) : div_q[SUM_W-1:0];
    assign scaled = neg_reg ? -$signed(q_sat) : $signed(q_sat);
    assign final_s = sat48($signed({{2{score_reg[SUM_W-1]}}, score_reg})
                    + (SUM_W+2)'($signed(prior_reg[ac_idx_reg[CLS_W-1:0]])));
    assign len_sum = {1'b0, len_reg} + (LEN_W+1)'(cnt_reg);
    // The dividend register is loaded at the end of the multiply cycle, so the
    // divider starts in the cycle after it, the first divide cycle.
    assign div_start = div_go_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_ch.mode == MODE_TERM)
                begin
                    state_next = (in_ch.feature_index < FEAT_W'(FEATURES - 1) ||
                                  in_ch.feature_index == FEAT_W'(FEATURES - 1)) ?
                                 ST_READ : (in_ch.last_term ? ST_FIN_READ : ST_IDLE);
                end
            end
            ST_READ:     state_next = ST_ACC;
            ST_ACC:
            begin
                if (ac_idx_reg == CI_W'(CLASSES - 1))
                    state_next = last_reg ? ST_FIN_READ : ST_IDLE;
            end
            ST_FIN_READ: state_next = norm_on ? ST_FIN_MUL : ST_FIN_CMP;
            ST_FIN_MUL:  state_next = ST_FIN_DIV;
            ST_FIN_DIV:  state_next = div_done ? ST_FIN_CMP : ST_FIN_DIV;
            ST_FIN_CMP:
            begin
                if (ac_idx_reg == active_reg - 1'b1)
                    state_next = ST_OUT;
                else
                    state_next = ST_FIN_READ;
            end
            ST_OUT:      state_next = (out_ch.ready) ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.predicted_class = best_cls_reg;
    assign out_ch.best_score      = best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            num_classes_reg <= CCNT_W'(8);
            length_norm_reg <= '0;
            out_valid_reg   <= 1'b0;
            div_go_reg      <= 1'b0;
            len_reg         <= '0;
            rd_idx_reg      <= '0;
            ac_idx_reg      <= '0;
            active_reg      <= CI_W'(1);
            for (int i = 0; i < CLASSES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == ST_FIN_MUL);
            if (cfg_we && cfg_index == REG_CLASS_COUNT)
                num_classes_reg <= cfg_data[CCNT_W-1:0];
            if (cfg_we && cfg_index == REG_LENGTH_NORM)
                length_norm_reg <= cfg_data[NORM_W-1:0];

            unique case (state_reg)
                ST_IDLE:
                begin
                    // Class zero is read during the read cycle that follows an accept.
                    rd_idx_reg <= '0;
                    ac_idx_reg <= '0;
                    if (num_classes_reg == '0)
                        active_reg <= CI_W'(1);
                    else if (num_classes_reg > CCNT_W'(CLASSES))
                        active_reg <= CI_W'(CLASSES);
                    else
                        active_reg <= CI_W'(num_classes_reg);
                end
                ST_READ:
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                ST_ACC:
                begin
                    sum_reg[ac_idx_reg[CLS_W-1:0]] <= sat48(prod);
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    ac_idx_reg <= ac_idx_reg + 1'b1;
                    if (ac_idx_reg == CI_W'(CLASSES - 1))
                    begin
                        ac_idx_reg <= '0;
                        len_reg <= len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
                    end
                end
                ST_FIN_CMP:
                begin
                    if (ac_idx_reg == '0 || final_s > best_reg)
                    begin
                        best_reg     <= final_s;
                        best_cls_reg <= CCNT_W'(ac_idx_reg) + 1'b1;
                    end
                    ac_idx_reg <= ac_idx_reg + 1'b1;
                    if (ac_idx_reg == active_reg - 1'b1)
                    begin
                        out_valid_reg <= 1'b1;
                        len_reg <= '0;
                        for (int i = 0; i < CLASSES; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_ch.ready)
                        out_valid_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.mode == MODE_TERM)
        begin
            feat_reg <= in_ch.feature_index;
            cnt_reg  <= in_ch.term_count;
            last_reg <= in_ch.last_term;
        end
        if (in_fire && in_ch.mode == MODE_PRIOR)
            prior_reg[in_ch.class_index] <= in_ch.log_prob;
        if (state_reg == ST_FIN_READ)
        begin
            score_reg <= sum_reg[ac_idx_reg[CLS_W-1:0]];
            neg_reg   <= sum_reg[ac_idx_reg[CLS_W-1:0]][SUM_W-1];
        end
        if (state_reg == ST_FIN_MUL)
        begin
            // Magnitude times norm plus half the length, for rounding.
            divd_reg <= DIVD_W'(mag) * DIVD_W'(length_norm_reg)
                      + DIVD_W'(len_reg >> 1);
        end
        if (state_reg == ST_FIN_DIV && div_done)
            score_reg <= scaled;
    end

    assign mag = score_reg[SUM_W-1] ? SUM_W'(-score_reg) : SUM_W'(score_reg);
endmodule
